>>> sv/mcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants for the minimum coin change block.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int NUM_DENOM = 6;   // denomination registers
    localparam int DENOM_W   = 12;  // denomination value width
    localparam int AMOUNT_W  = 12;  // amount / coin count width
    localparam int IDX_W     = 3;   // denomination index width

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DENOM_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DENOM_FIRST = 3'd1;

    // live configuration handed to the engine
    typedef struct packed {
        logic [IDX_W-1:0]                   active;  // denominations in use, 1..6
        logic [NUM_DENOM-1:0][DENOM_W-1:0]  denom;
    } t_cfg;

    // one table entry: unreachable flag, fewest coins, last coin's denomination
    typedef struct packed {
        logic                unr;
        logic [AMOUNT_W-1:0] count;
        logic [IDX_W-1:0]    choice;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> sv/mcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mcc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_cfg
// Configuration registers: denomination count and denomination values.
// ----------------------------------------------------------------------------
module mcc_cfg #(
    parameter int MAX_DENOMS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [mcc_pkg::IDX_W-1:0]  i_index,
    input  logic [mcc_pkg::DENOM_W-1:0] i_data,
    output mcc_pkg::t_cfg              o_cfg
);

    localparam int CAP = (MAX_DENOMS < mcc_pkg::NUM_DENOM) ? MAX_DENOMS : mcc_pkg::NUM_DENOM;
    localparam logic [mcc_pkg::IDX_W-1:0] CAP_N = mcc_pkg::IDX_W'(CAP);

    logic [mcc_pkg::IDX_W-1:0]   r_count;
    logic [mcc_pkg::NUM_DENOM-1:0][mcc_pkg::DENOM_W-1:0] r_denom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= mcc_pkg::IDX_W'(1);
            for (int j = 0; j < mcc_pkg::NUM_DENOM; j++) begin
                r_denom[j] <= mcc_pkg::DENOM_W'(1);
            end
        end else if (i_we) begin
            if (i_index == mcc_pkg::CFG_DENOM_COUNT) begin
                r_count <= i_data[mcc_pkg::IDX_W-1:0];
            end
            for (int j = 0; j < mcc_pkg::NUM_DENOM; j++) begin
                if (i_index == mcc_pkg::CFG_DENOM_FIRST + mcc_pkg::IDX_W'(j)) begin
                    r_denom[j] <= i_data;
                end
            end
        end
    end

    // zero counts as one, anything above the cap saturates
    always_comb begin
        priority if (r_count == '0) begin
            o_cfg.active = mcc_pkg::IDX_W'(1);
        end else if (r_count > CAP_N) begin
            o_cfg.active = CAP_N;
        end else begin
            o_cfg.active = r_count;
        end
        o_cfg.denom = r_denom;
    end

endmodule

>>> sv/min_coin_change.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_coin_change
// Fewest-coin split of an amount over up to six denominations. Fills a
// min-coin table in RAM for every amount up to the request, traces back
// one coin at a time, then emits one count per active denomination.
// ----------------------------------------------------------------------------
// Fill: each amount up to the request A takes N reads, one per active
//   denomination, plus one write, with N the active denominations.
//   The table RAM never reads and writes in the same cycle.
// Throughput: one request at a time; next accepted once the last result loads.
// Reset: control and denominations return to defaults; table is not cleared.
// ----------------------------------------------------------------------------
module min_coin_change #(
    parameter int MAX_DENOMS = 6,
    parameter int MAX_AMOUNT = 4095
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mcc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [mcc_pkg::DENOM_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mcc_pkg::AMOUNT_W-1:0]  i_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mcc_pkg::IDX_W-1:0]     o_denom_index,
    output logic [mcc_pkg::AMOUNT_W-1:0]  o_coin_count,
    output logic                          o_unreachable,
    output logic                          o_last
);

    localparam int TOP   = (MAX_AMOUNT < 4095) ? MAX_AMOUNT : 4095;
    localparam int DEPTH = TOP + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [mcc_pkg::AMOUNT_W-1:0] TOP_AMT = mcc_pkg::AMOUNT_W'(TOP);
    localparam logic [mcc_pkg::AMOUNT_W:0]   UNR_BEST = {1'b1, {mcc_pkg::AMOUNT_W{1'b0}}};
    localparam logic [mcc_pkg::IDX_W-1:0]    NDEN = mcc_pkg::IDX_W'(mcc_pkg::NUM_DENOM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_FILL,
        S_TRACE_RD,
        S_TRACE_CHK,
        S_EMIT
    } t_state;

    mcc_pkg::t_cfg cfg;

    t_state r_state;
    logic [mcc_pkg::AMOUNT_W-1:0] r_amount;
    logic [mcc_pkg::AMOUNT_W-1:0] r_a;
    logic [mcc_pkg::IDX_W-1:0]    r_k;
    logic                         r_pv;
    logic [mcc_pkg::IDX_W-1:0]    r_pk;
    logic [mcc_pkg::AMOUNT_W:0]   r_best;
    logic [mcc_pkg::IDX_W-1:0]    r_choice;
    logic                         r_first;
    logic                         r_unr;
    logic [mcc_pkg::IDX_W-1:0]    r_e;
    logic [mcc_pkg::NUM_DENOM-1:0][mcc_pkg::AMOUNT_W-1:0] r_tally;

    logic                         r_out_valid;
    logic [mcc_pkg::IDX_W-1:0]    r_out_idx;
    logic [mcc_pkg::AMOUNT_W-1:0] r_out_cnt;
    logic                         r_out_unr;
    logic                         r_out_last;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [mcc_pkg::ENTRY_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [mcc_pkg::ENTRY_W-1:0]  ram_rdata;
    mcc_pkg::t_entry              prev;
    mcc_pkg::t_entry              wr_entry;

    logic                         issue_go;
    logic                         issue_ok;
    logic [mcc_pkg::DENOM_W-1:0]  d_k;
    logic [mcc_pkg::AMOUNT_W-1:0] fill_addr;
    logic [mcc_pkg::AMOUNT_W:0]   prev_inc;
    logic [mcc_pkg::AMOUNT_W:0]   cand_best;
    logic [mcc_pkg::IDX_W-1:0]    cand_choice;
    logic [mcc_pkg::IDX_W-1:0]    t_c;
    logic [mcc_pkg::DENOM_W-1:0]  t_d;
    logic                         t_stop;
    logic                         out_free;

    mcc_cfg #(
        .MAX_DENOMS (MAX_DENOMS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mcc_ram #(
        .WIDTH (mcc_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign prev = mcc_pkg::t_entry'(ram_rdata);

    // fill: one read per denomination, compare as data returns, write in the cycle
    // of the last compare; the next amount's reads start the cycle after the write
    always_comb begin
        issue_go  = (r_state == S_FILL) && (r_k < cfg.active);
        d_k       = (r_k < NDEN) ? cfg.denom[r_k] : '0;
        issue_ok  = (d_k != '0) && (d_k <= r_a);
        fill_addr = r_a - d_k;
        prev_inc  = {1'b0, prev.count} + 1'b1;

        cand_best   = r_best;
        cand_choice = r_choice;
        if (r_pv && !prev.unr && (prev_inc < r_best)) begin
            cand_best   = prev_inc;
            cand_choice = r_pk;
        end

        ram_re    = issue_go || (r_state == S_TRACE_RD);
        ram_raddr = (r_state == S_FILL) ? fill_addr[AW-1:0] : r_a[AW-1:0];

        ram_we         = (r_state == S_INIT) || ((r_state == S_FILL) && !issue_go);
        wr_entry.unr   = cand_best[mcc_pkg::AMOUNT_W];
        wr_entry.count = cand_best[mcc_pkg::AMOUNT_W-1:0];
        wr_entry.choice = cand_choice;
        if (r_state == S_INIT) begin
            ram_waddr = '0;
            ram_wdata = '0;
        end else begin
            ram_waddr = r_a[AW-1:0];
            ram_wdata = wr_entry;
        end
    end

    // traceback step
    always_comb begin
        t_c    = prev.choice;
        t_d    = (t_c < NDEN) ? cfg.denom[t_c] : '0;
        t_stop = (r_first && prev.unr) || (r_a == '0) || (t_c >= cfg.active) ||
                 (t_d == '0) || (t_d > r_a);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_k         <= '0;
            r_first     <= 1'b0;
            r_unr       <= 1'b0;
            r_e         <= '0;
            r_tally     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_amount <= i_amount;
                        r_tally  <= '0;
                        r_e      <= '0;
                        if (i_amount > TOP_AMT) begin
                            r_unr   <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_unr   <= 1'b0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_k      <= '0;
                    r_pv     <= 1'b0;
                    r_best   <= UNR_BEST;
                    r_choice <= '0;
                    r_first  <= 1'b1;
                    if (r_amount == '0) begin
                        r_a     <= '0;
                        r_state <= S_TRACE_RD;
                    end else begin
                        r_a     <= mcc_pkg::AMOUNT_W'(1);
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (issue_go) begin
                        r_best   <= cand_best;
                        r_choice <= cand_choice;
                        r_pv     <= issue_ok;
                        r_pk     <= r_k;
                        r_k      <= r_k + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (r_a == r_amount) begin
                            r_state <= S_TRACE_RD;
                        end else begin
                            r_a      <= r_a + 1'b1;
                            r_k      <= '0;
                            r_best   <= UNR_BEST;
                            r_choice <= '0;
                        end
                    end
                end
                S_TRACE_RD: begin
                    r_state <= S_TRACE_CHK;
                end
                S_TRACE_CHK: begin
                    r_first <= 1'b0;
                    if (t_stop) begin
                        if (r_first && prev.unr) begin
                            r_unr <= 1'b1;
                        end
                        r_e     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        for (int j = 0; j < mcc_pkg::NUM_DENOM; j++) begin
                            if (t_c == mcc_pkg::IDX_W'(j)) begin
                                r_tally[j] <= r_tally[j] + 1'b1;
                            end
                        end
                        r_a     <= r_a - t_d;
                        r_state <= S_TRACE_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_e;
                        r_out_cnt   <= r_unr ? '0 : r_tally[r_e];
                        r_out_unr   <= r_unr;
                        r_out_last  <= (r_e == cfg.active - 1'b1);
                        if (r_e == cfg.active - 1'b1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_e <= r_e + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_denom_index = r_out_idx;
    assign o_coin_count  = r_out_cnt;
    assign o_unreachable = r_out_unr;
    assign o_last        = r_out_last;

    // table port never reads and writes in the same cycle
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("table read and write in the same cycle");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_denom_index == cfg.active - 1'b1))
        else $error("last flag not on final denomination");

    a_unr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unreachable) |-> (o_coin_count == '0))
        else $error("unreachable result with nonzero count");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_k <= cfg.active))
        else $error("fill read index past active denominations");

endmodule

>>> tb/tb_min_coin_change.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_coin_change
// Self-checking bench for the fewest-coin splitter. Amounts are queued per
// denomination setup and pushed through the valid/stall input. Each accepted
// amount is run through a local dynamic-program model and its per-denomination
// counts are queued. The output monitor checks every transaction against them.
// ----------------------------------------------------------------------------
module tb_min_coin_change;

    localparam int TABLE_DEPTH = 4096;
    localparam int HOLD_CYCLES = 3000;   // long output hold-off, input backs up
    localparam int NO_WAY      = 'h1000; // table marker for an unreachable amount

    typedef struct packed {
        logic [mcc_pkg::IDX_W-1:0]    denom_index;
        logic [mcc_pkg::AMOUNT_W-1:0] coin_count;
        logic                         unreachable;
        logic                         last;
    } t_coin_result;

    typedef struct packed {
        logic [mcc_pkg::AMOUNT_W-1:0] amount;
        logic                         drain_first;   // hold back until all counts are back
    } t_amount_req;

    typedef logic [mcc_pkg::DENOM_W-1:0] t_denom_set [mcc_pkg::NUM_DENOM];

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [mcc_pkg::IDX_W-1:0]     i_cfg_index = '0;
    logic [mcc_pkg::DENOM_W-1:0]   i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [mcc_pkg::AMOUNT_W-1:0]  i_amount = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [mcc_pkg::IDX_W-1:0]     o_denom_index;
    logic [mcc_pkg::AMOUNT_W-1:0]  o_coin_count;
    logic                          o_unreachable;
    logic                          o_last;

    min_coin_change DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_denom_index (o_denom_index),
        .o_coin_count  (o_coin_count),
        .o_unreachable (o_unreachable),
        .o_last        (o_last)
    );

    // shadow of the denomination registers
    logic [mcc_pkg::IDX_W-1:0]   cfg_count = 3'd1;
    t_denom_set                  cfg_denom = '{default: 12'd1};
    t_denom_set                  next_denoms;

    // local copy of the min-coin table
    logic [12:0]                 dp_count  [TABLE_DEPTH];
    logic [mcc_pkg::IDX_W-1:0]   dp_choice [TABLE_DEPTH];

    t_amount_req        amount_q[$];
    t_coin_result       owed_counts[$];

    int send_pct = 0;
    int recv_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int mismatches = 0;
    int results_checked = 0;
    int amounts_split = 0;
    int unreach_amounts = 0;
    int largest_amount = 0;
    int setups = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // fewest-coin split of one amount under the current setup
    function automatic void predict_split(input logic [mcc_pkg::AMOUNT_W-1:0] amt);
        int           n;
        int           best;
        int           pick;
        int           prev;
        int           rest;
        int           c;
        int           d;
        int           tally [mcc_pkg::NUM_DENOM];
        logic         no_way;
        t_coin_result r;
        if (cfg_count == 0)
            n = 1;
        else if (cfg_count > mcc_pkg::NUM_DENOM)
            n = mcc_pkg::NUM_DENOM;
        else
            n = int'(cfg_count);
        for (int i = 0; i < mcc_pkg::NUM_DENOM; i++)
            tally[i] = 0;
        dp_count[0]  = '0;
        dp_choice[0] = '0;
        for (int a = 1; a <= amt; a++) begin
            best = NO_WAY;
            pick = 0;
            for (int i = 0; i < n; i++) begin
                if (cfg_denom[i] == 0 || cfg_denom[i] > a)
                    continue;
                prev = dp_count[a - cfg_denom[i]];
                if (prev >= NO_WAY)
                    continue;
                // strict compare: the lower index keeps a tie
                if (prev + 1 < best) begin
                    best = prev + 1;
                    pick = i;
                end
            end
            dp_count[a]  = best[12:0];
            dp_choice[a] = pick[mcc_pkg::IDX_W-1:0];
        end
        no_way = dp_count[amt][12];
        if (!no_way) begin
            rest = amt;
            while (rest > 0) begin
                c = dp_choice[rest];
                if (c >= n)
                    break;
                d = cfg_denom[c];
                if (d == 0 || d > rest)
                    break;
                tally[c] = (tally[c] + 1) & 'hFFF;
                rest -= d;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.denom_index = i[mcc_pkg::IDX_W-1:0];
            r.coin_count  = no_way ? '0 : tally[i][mcc_pkg::AMOUNT_W-1:0];
            r.unreachable = no_way;
            r.last        = (i == n - 1);
            owed_counts   = {owed_counts, r};
        end
        amounts_split++;
        if (no_way)
            unreach_amounts++;
        if (amt > largest_amount)
            largest_amount = amt;
    endfunction

    // input driver: one amount per transaction, held until taken
    always @(posedge i_clk) begin
        logic        keep_valid;
        t_amount_req nxt;
        keep_valid = i_in_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_split(i_amount);
                keep_valid = 1'b0;
            end
            if (!keep_valid && amount_q.size() != 0
                    && !(amount_q[0].drain_first && owed_counts.size() != 0)
                    && $urandom_range(0, 99) >= send_pct) begin
                nxt = amount_q.pop_front();
                i_amount <= nxt.amount;
                keep_valid = 1'b1;
            end
            i_in_valid <= keep_valid;
        end
    end

    // output stall: random, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_coin_result got;
        t_coin_result want;
        got = '{o_denom_index, o_coin_count, o_unreachable, o_last};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transaction idx=%0d count=%0d unr=%0b last=%0b",
                             $realtime, got.denom_index, got.coin_count, got.unreachable,
                             got.last);
            end else begin
                want = owed_counts.pop_front();
                results_checked++;
                if (got.denom_index !== want.denom_index
                        || got.coin_count !== want.coin_count
                        || got.unreachable !== want.unreachable
                        || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch exp idx=%0d count=%0d unr=%0b last=%0b",
                                  " got idx=%0d count=%0d unr=%0b last=%0b"}, $realtime,
                                 want.denom_index, want.coin_count, want.unreachable,
                                 want.last, got.denom_index, got.coin_count,
                                 got.unreachable, got.last);
                end
            end
        end
    end

    function automatic void queue_amount(input int amt, input logic drain);
        t_amount_req req;
        req.amount      = amt[mcc_pkg::AMOUNT_W-1:0];
        req.drain_first = drain;
        amount_q        = {amount_q, req};
    endfunction

    task automatic wait_drained();
        while (amount_q.size() != 0 || i_in_valid || owed_counts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // writes the count register, then all six denominations from next_denoms
    task automatic load_setup(input logic [mcc_pkg::DENOM_W-1:0] count_word);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mcc_pkg::CFG_DENOM_COUNT;
        i_cfg_data  <= count_word;
        cfg_count    = count_word[mcc_pkg::IDX_W-1:0];
        for (int i = 0; i < mcc_pkg::NUM_DENOM; i++) begin
            @(posedge i_clk);
            i_cfg_index <= mcc_pkg::IDX_W'(mcc_pkg::CFG_DENOM_FIRST + i);
            i_cfg_data  <= next_denoms[i];
            cfg_denom[i] = next_denoms[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setups++;
        @(negedge i_clk);
    endtask

    initial begin
        int r;
        int cnt;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setup: one denomination of value one
        queue_amount(0, 1'b0);
        queue_amount(1, 1'b0);
        queue_amount(4095, 1'b0);
        wait_drained();

        // greedy-breaking set plus the largest denomination
        next_denoms = '{12'd1, 12'd3, 12'd4, 12'd4095, 12'd2048, 12'd7};
        load_setup(12'd6);
        send_pct = 71;
        queue_amount(6, 1'b0);
        queue_amount(13, 1'b0);
        queue_amount(4095, 1'b0);
        queue_amount(2047, 1'b0);
        queue_amount(4094, 1'b0);
        queue_amount(0, 1'b0);
        wait_drained();

        // equal denominations tie, a zero denomination in use, gaps
        next_denoms = '{12'd5, 12'd5, 12'd0, 12'd2, 12'd1, 12'd1};
        load_setup(12'd4);
        send_pct = 0;
        recv_pct = 71;
        queue_amount(1, 1'b0);
        queue_amount(3, 1'b0);
        queue_amount(7, 1'b0);
        queue_amount(10, 1'b0);
        queue_amount(0, 1'b0);
        wait_drained();

        // count zero behaves as one
        next_denoms = '{12'd3, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1};
        load_setup(12'd0);
        send_pct = 13;
        recv_pct = 13;
        queue_amount(9, 1'b0);
        queue_amount(10, 1'b0);
        queue_amount(4095, 1'b0);
        wait_drained();

        // count seven saturates to six, all denominations at the top value
        next_denoms = '{default: 12'd4095};
        load_setup(12'd7);
        send_pct = 0;
        recv_pct = 0;
        queue_amount(4095, 1'b0);
        queue_amount(100, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            foreach (next_denoms[i]) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    next_denoms[i] = '0;
                else if (r < 15)
                    next_denoms[i] = 12'd1;
                else if (r < 80)
                    next_denoms[i] = mcc_pkg::DENOM_W'($urandom_range(2, 24));
                else
                    next_denoms[i] = mcc_pkg::DENOM_W'($urandom_range(1, 4095));
            end
            // upper bits of the count word are don't-care
            cnt = $urandom_range(0, 7);
            load_setup({mcc_pkg::DENOM_W'($urandom_range(0, 511)) << mcc_pkg::IDX_W}
                       | mcc_pkg::DENOM_W'(cnt));
            case (ph)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 71; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 71; end
                default: begin send_pct = 13; recv_pct = 13; end
            endcase
            // back up the output so the input stalls while amounts keep coming
            if (ph == 0)
                hold_req++;
            for (int k = 0; k < 20; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    queue_amount($urandom_range(0, 31), k == 10);
                else if (r < 95)
                    queue_amount($urandom_range(0, 400), k == 10);
                else
                    queue_amount($urandom_range(0, 4095), k == 10);
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        $display("Split %0d amounts (largest %0d, %0d unreachable) over %0d setups;",
                 amounts_split, largest_amount, unreach_amounts, setups);
        $display("checked %0d coin-count transactions, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && owed_counts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout: %0d amounts queued, %0d counts outstanding",
                 amount_q.size(), owed_counts.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
